[src/met_pkg.sv]
// Shared types, constants and helpers of the Mandelbrot escape-time core.
package met_pkg;

    localparam int COORD_W     = 32;
    localparam int IDX_W       = 10;
    localparam int COUNT_W     = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int RING_DEPTH  = 4;
    localparam int TAG_W       = $clog2(RING_DEPTH);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_REAL_MIN        = 3'd0,
        REG_IMAG_MIN        = 3'd1,
        REG_REAL_STEP       = 3'd2,
        REG_IMAG_STEP       = 3'd3,
        REG_ITERATION_LIMIT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
    } in_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0] escape_count;
        logic [IDX_W-1:0]   pixel_column;
        logic [IDX_W-1:0]   pixel_row;
    } out_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] real_min;
        logic signed [COORD_W-1:0] imag_min;
        logic signed [COORD_W-1:0] real_step;
        logic signed [COORD_W-1:0] imag_step;
        logic [COUNT_W-1:0]        iteration_limit;
    } cfg_t;

    // A mapped pixel: the point c and the pixel it came from.
    typedef struct packed {
        logic signed [COORD_W-1:0] cr;
        logic signed [COORD_W-1:0] ci;
        logic [IDX_W-1:0]          column;
        logic [IDX_W-1:0]          row;
    } point_t;

    // One slot of the iteration ring. k counts the updates made so far;
    // once done is set it holds the escape count.
    typedef struct packed {
        logic                      valid;
        logic                      done;
        logic [TAG_W-1:0]          tag;
        logic [COUNT_W-1:0]        k;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] cr;
        logic signed [COORD_W-1:0] ci;
        logic [IDX_W-1:0]          column;
        logic [IDX_W-1:0]          row;
    } slot_t;

    localparam cfg_t CFG_RESET = '{
        real_min:        32'shE000_0000,
        imag_min:        32'shE000_0000,
        real_step:       32'sh0010_0000,
        imag_step:       32'sh0010_0000,
        iteration_limit: 12'd64
    };

    localparam logic signed [65:0] SAT_HI = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] SAT_LO = -66'sh0_8000_0000;

    // Clamp a wide signed value to the signed coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [65:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[COORD_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

[src/met_coord.sv]
// Two-stage pixel-to-point mapping: c = minimum + index * step on each axis.
module met_coord (
    input  logic              aclk,
    input  logic              aresetn,
    input  met_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  met_pkg::in_word_t in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output met_pkg::point_t   out_point
);

    localparam int PROD_W = met_pkg::COORD_W + met_pkg::IDX_W + 1;

    logic                             e1_valid_reg, e1_valid_next;
    logic                             e2_valid_reg, e2_valid_next;
    logic signed [PROD_W-1:0]         prod_r_reg, prod_r_next;
    logic signed [PROD_W-1:0]         prod_i_reg, prod_i_next;
    logic [met_pkg::IDX_W-1:0]        col_reg, row_reg;
    met_pkg::point_t                  point_reg, point_next;
    logic                             in_fire;
    logic                             e2_load;

    assign e2_load  = e1_valid_reg && (!e2_valid_reg || out_ready);
    assign in_ready = !e1_valid_reg || e2_load;
    assign in_fire  = in_valid && in_ready;

    always_comb begin
        prod_r_next = PROD_W'($signed({1'b0, in_word.column})) * PROD_W'(cfg.real_step);
        prod_i_next = PROD_W'($signed({1'b0, in_word.row})) * PROD_W'(cfg.imag_step);
    end

    always_comb begin
        point_next.cr     = met_pkg::sat_coord(66'(prod_r_reg) + 66'(cfg.real_min));
        point_next.ci     = met_pkg::sat_coord(66'(prod_i_reg) + 66'(cfg.imag_min));
        point_next.column = col_reg;
        point_next.row    = row_reg;
    end

    always_comb begin
        e1_valid_next = e1_valid_reg;
        if (in_fire) begin
            e1_valid_next = 1'b1;
        end else if (e2_load) begin
            e1_valid_next = 1'b0;
        end
        e2_valid_next = e2_valid_reg;
        if (e2_load) begin
            e2_valid_next = 1'b1;
        end else if (out_ready) begin
            e2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
        end else begin
            e1_valid_reg <= e1_valid_next;
            e2_valid_reg <= e2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            prod_r_reg <= prod_r_next;
            prod_i_reg <= prod_i_next;
            col_reg    <= in_word.column;
            row_reg    <= in_word.row;
        end
        if (e2_load) begin
            point_reg <= point_next;
        end
    end

    assign out_valid = e2_valid_reg;
    assign out_point = point_reg;

endmodule

[src/met_ring.sv]
// Four-stage iteration ring: z = z*z + c with in-order retirement of pixels.
module met_ring #(
    parameter int FRAC_BITS = 28
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [met_pkg::COUNT_W-1:0] limit,
    input  logic                        ins_valid,
    output logic                        ins_ready,
    input  met_pkg::point_t             ins_point,
    output logic                        ret_valid,
    input  logic                        ret_ready,
    output met_pkg::out_word_t          ret_word
);

    localparam int CW    = met_pkg::COORD_W;
    localparam int PW    = 2 * CW;
    localparam int MAG_W = (2 * FRAC_BITS + 3 > PW + 1) ? 2 * FRAC_BITS + 3 : PW + 1;
    localparam logic [MAG_W-1:0] ESC_BOUND = MAG_W'(1) << (2 * FRAC_BITS + 2);

    met_pkg::slot_t s0_reg, s0_next;
    met_pkg::slot_t s1_reg, s1_next;
    met_pkg::slot_t s2_reg, s2_next;
    met_pkg::slot_t s3_reg, s3_next;

    logic signed [PW-1:0] xx_reg, xx_next;
    logic signed [PW-1:0] yy_reg, yy_next;
    logic signed [PW-1:0] xy_reg, xy_next;
    logic signed [PW:0]   diff_reg, diff_next;
    logic signed [PW-1:0] xy2_reg, xy2_next;
    logic                 esc_reg, esc_next;

    logic [met_pkg::TAG_W-1:0] issue_tag_reg, issue_tag_next;
    logic [met_pkg::TAG_W-1:0] retire_tag_reg, retire_tag_next;

    logic [PW:0]          mag;
    logic signed [CW-1:0] nx, ny;
    logic                 retire;
    logic                 ins_fire;

    assign ret_valid = s3_reg.valid && s3_reg.done && (s3_reg.tag == retire_tag_reg);
    assign retire    = ret_valid && ret_ready;
    assign ins_ready = !s3_reg.valid || retire;
    assign ins_fire  = ins_valid && ins_ready;

    assign ret_word.escape_count = s3_reg.k;
    assign ret_word.pixel_column = s3_reg.column;
    assign ret_word.pixel_row    = s3_reg.row;

    // Ring head: a slot coming round again has priority over a new pixel.
    always_comb begin
        s0_next = s3_reg;
        if (s3_reg.valid && !retire) begin
            s0_next = s3_reg;
        end else if (ins_valid) begin
            s0_next.valid  = 1'b1;
            s0_next.done   = 1'b0;
            s0_next.tag    = issue_tag_reg;
            s0_next.k      = '0;
            s0_next.x      = '0;
            s0_next.y      = '0;
            s0_next.cr     = ins_point.cr;
            s0_next.ci     = ins_point.ci;
            s0_next.column = ins_point.column;
            s0_next.row    = ins_point.row;
        end else begin
            s0_next.valid = 1'b0;
        end
        issue_tag_next  = ins_fire ? issue_tag_reg + 1'b1 : issue_tag_reg;
        retire_tag_next = retire ? retire_tag_reg + 1'b1 : retire_tag_reg;
    end

    // Products of the current z.
    always_comb begin
        s1_next = s0_reg;
        xx_next = PW'(s0_reg.x) * PW'(s0_reg.x);
        yy_next = PW'(s0_reg.y) * PW'(s0_reg.y);
        xy_next = PW'(s0_reg.x) * PW'(s0_reg.y);
    end

    // Escape test on |z|^2 and the real-part difference.
    always_comb begin
        s2_next   = s1_reg;
        mag       = {1'b0, xx_reg} + {1'b0, yy_reg};
        esc_next  = MAG_W'(mag) >= ESC_BOUND;
        diff_next = {xx_reg[PW-1], xx_reg} - {yy_reg[PW-1], yy_reg};
        xy2_next  = xy_reg;
    end

    // Rescale, add c, saturate; then decide whether the pixel is finished.
    always_comb begin
        nx = met_pkg::sat_coord(66'(diff_reg >>> FRAC_BITS) + 66'(s2_reg.cr));
        ny = met_pkg::sat_coord(66'(xy2_reg >>> (FRAC_BITS - 1)) + 66'(s2_reg.ci));
        s3_next = s2_reg;
        if (s2_reg.valid && !s2_reg.done) begin
            if ((s2_reg.k != '0) && esc_reg) begin
                s3_next.done = 1'b1;
                s3_next.k    = s2_reg.k - met_pkg::COUNT_W'(1);
            end else if (s2_reg.k == limit) begin
                s3_next.done = 1'b1;
            end else begin
                s3_next.x = nx;
                s3_next.y = ny;
                s3_next.k = s2_reg.k + met_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_reg.valid   <= 1'b0;
            s1_reg.valid   <= 1'b0;
            s2_reg.valid   <= 1'b0;
            s3_reg.valid   <= 1'b0;
            issue_tag_reg  <= '0;
            retire_tag_reg <= '0;
        end else begin
            s0_reg         <= s0_next;
            s1_reg         <= s1_next;
            s2_reg         <= s2_next;
            s3_reg         <= s3_next;
            issue_tag_reg  <= issue_tag_next;
            retire_tag_reg <= retire_tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        xx_reg   <= xx_next;
        yy_reg   <= yy_next;
        xy_reg   <= xy_next;
        diff_reg <= diff_next;
        xy2_reg  <= xy2_next;
        esc_reg  <= esc_next;
    end

`ifndef NO_ASSERTIONS
    a_count_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        retire |-> (ret_word.escape_count <= limit))
        else $error("retired escape count exceeds the iteration limit");

    a_slot_k_bounded : assert property (@(posedge aclk) disable iff (!aresetn)
        s3_reg.valid |-> (s3_reg.k <= limit))
        else $error("ring slot has made more updates than the limit allows");

    a_tag_accounting : assert property (@(posedge aclk) disable iff (!aresetn)
        (issue_tag_reg - retire_tag_reg) == met_pkg::TAG_W'($countones(
            {s0_reg.valid, s1_reg.valid, s2_reg.valid, s3_reg.valid})))
        else $error("pixels in the ring disagree with issued minus retired");
`endif

endmodule

[src/mandelbrot_escape_time_core.sv]
// Mandelbrot escape-time core: configuration registers, mapping, ring and output word.
//
// A word on the s_ channel names one pixel (column, row). The core maps it to
// c = minimum + index * step on each axis (signed fixed point, FRAC_BITS fraction
// bits in 32 bits, saturated), iterates z = z*z + c from zero and returns one m_
// word per pixel: the escape count and the pixel's own column and row. Results
// leave in the order the pixels were accepted. Configuration words on the cfg_
// channel (index 0..4, other indices ignored) are taken in any cycle and are to
// be written only while the core holds no pixel.
// A pixel passes the mapping stages and then goes round the ring, escape_count + 2
// passes for a pixel that escapes and iteration_limit + 1 for one that does not;
// the finished word then moves to the output register. The ring holds four
// pixels, so up to four pixels iterate together, with a slow pixel holding back
// younger finished ones behind it. A new word can be accepted in any cycle that the
// mapping stages have room. Reset restores the default view and clears all
// valid state. A stalled m_ channel holds its word; finished pixels keep
// circulating in the ring without loss until they can be delivered.
module mandelbrot_escape_time_core #(
    parameter int FRAC_BITS = 28
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  met_pkg::in_word_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output met_pkg::out_word_t              m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [met_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [met_pkg::COORD_W-1:0]     cfg_data
);

    met_pkg::cfg_t      cfg_reg, cfg_next;
    met_pkg::point_t    point;
    logic               point_valid;
    logic               point_ready;
    logic               ret_valid;
    logic               ret_ready;
    met_pkg::out_word_t ret_word;
    logic               m_valid_reg, m_valid_next;
    met_pkg::out_word_t m_data_reg;

    // Register writes are always accepted.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                met_pkg::REG_REAL_MIN:        cfg_next.real_min  = cfg_data;
                met_pkg::REG_IMAG_MIN:        cfg_next.imag_min  = cfg_data;
                met_pkg::REG_REAL_STEP:       cfg_next.real_step = cfg_data;
                met_pkg::REG_IMAG_STEP:       cfg_next.imag_step = cfg_data;
                met_pkg::REG_ITERATION_LIMIT: begin
                    cfg_next.iteration_limit = cfg_data[met_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= met_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Pixel to point mapping, two pipeline stages with their own handshake.
    met_coord u_coord (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (s_data),
        .out_valid (point_valid),
        .out_ready (point_ready),
        .out_point (point)
    );

    // The ring never stalls; it only takes a new point when its head slot is free.
    met_ring #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .limit     (cfg_reg.iteration_limit),
        .ins_valid (point_valid),
        .ins_ready (point_ready),
        .ins_point (point),
        .ret_valid (ret_valid),
        .ret_ready (ret_ready),
        .ret_word  (ret_word)
    );

    // Output register: a finished word may be replaced in the cycle it is taken.
    assign ret_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ret_valid && ret_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ret_valid && ret_ready) begin
            m_data_reg <= ret_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
